>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/hbpf_pkg.sv
`default_nettype none

package hbpf_pkg;

    localparam int FS_HZ = 256;
    localparam int LOW_HZ = 80;
    localparam int HIGH_HZ = 128;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] Q30_HALF = 64'd536870912;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] WIN_A = 64'sd579820585;
    localparam logic signed [63:0] WIN_B = 64'sd493921239;
    localparam logic signed [63:0] CENTRE_TAP_Q30 =
        64'((((64'd2 * 64'(HIGH_HZ - LOW_HZ)) << 30) + 64'(FS_HZ / 2)) / 64'(FS_HZ));

    typedef struct packed {
        logic load;
        logic read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_tap;
        logic pipe_idle;
    } status_t;

    // Restoring division, used only while the coefficient table is elaborated.
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den,
                                         input logic want_rem);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return want_rem ? rem[63:0] : quo;
    endfunction

    function automatic logic signed [63:0] cos_quarter(input logic [63:0] rem,
                                                       input logic [63:0] den);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] d;
        logic signed [63:0] sum;
        x = udiv(HALF_PI_Q30 * rem + (den >> 1), den, 1'b0);
        x2 = (x * x + Q30_HALF) >> 30;
        term = Q30_ONE;
        sum = $signed(Q30_ONE);
        for (int k = 1; k <= 12; k++) begin
            d = 64'(2 * k - 1) * 64'(2 * k);
            term = (term * x2 + Q30_HALF) >> 30;
            term = udiv(term + (d >> 1), d, 1'b0);
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] cos_turn(input logic signed [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] quad;
        logic [63:0] rem;
        logic signed [63:0] res;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        r = udiv(mag, den, 1'b1);
        if ((num < 0) && (r != 64'd0)) begin
            r = den - r;
        end
        t = r << 2;
        quad = udiv(t, den, 1'b0);
        rem = udiv(t, den, 1'b1);
        unique case (quad[1:0])
            2'd0: res = cos_quarter(rem, den);
            2'd1: res = -cos_quarter(den - rem, den);
            2'd2: res = -cos_quarter(rem, den);
            default: res = cos_quarter(den - rem, den);
        endcase
        return res;
    endfunction

    function automatic logic signed [63:0] sin_tone(input logic signed [63:0] f,
                                                    input logic signed [63:0] n);
        return cos_turn(64'sd4 * f * n - 64'(FS_HZ), 64'(4 * FS_HZ));
    endfunction

    // Hamming-windowed band-pass tap, rounded and saturated to coef_bits bits.
    function automatic logic signed [63:0] coef_value(input int idx, input int taps,
                                                      input int coef_bits);
        logic signed [63:0] n;
        logic signed [63:0] h;
        logic signed [63:0] w;
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic signed [63:0] cmax;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        int s;
        s = 61 - coef_bits;
        cmax = (64'sd1 <<< (coef_bits - 1)) - 64'sd1;
        n = 64'(idx) - 64'((taps - 1) / 2);
        if (n == 64'sd0) begin
            h = CENTRE_TAP_Q30;
        end else begin
            d = sin_tone(64'(HIGH_HZ), n) - sin_tone(64'(LOW_HZ), n);
            mag = ((d < 0) ? 64'(-d) : 64'(d)) << 30;
            den = PI_Q30 * ((n < 0) ? 64'(-n) : 64'(n));
            q = udiv(mag + (den >> 1), den, 1'b0);
            h = ((d < 0) != (n < 0)) ? -$signed(q) : $signed(q);
        end
        w = WIN_A - ((WIN_B * cos_turn(64'(idx), 64'(taps - 1)) + $signed(Q30_HALF)) >>> 30);
        c = (h * w + (64'sd1 <<< (s - 1))) >>> s;
        if (c > cmax) begin
            c = cmax;
        end
        if (c < -cmax - 64'sd1) begin
            c = -cmax - 64'sd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hbpf_ctrl.sv
`default_nettype none

module hbpf_ctrl #(
    parameter int TAPS = 401
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_record_start,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hbpf_pkg::cmd_t        cmd,
    input  wire hbpf_pkg::status_t status
);

    localparam int WARM_BITS = $clog2(TAPS + 2);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [WARM_BITS-1:0] warm_reg, warm_next;
    logic [WARM_BITS-1:0] warm_base;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign warm_base = s_record_start ? '0 : warm_reg;

    always_comb begin
        state_next = state_reg;
        warm_next = warm_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (warm_base >= WARM_BITS'(TAPS)) begin
                        warm_next = WARM_BITS'(TAPS + 1);
                        state_next = ST_RUN;
                    end else begin
                        warm_next = warm_base + 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.read = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_idle) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            warm_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            warm_reg <= warm_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hbpf_datapath.sv
`default_nettype none

module hbpf_datapath #(
    parameter int TAPS = 401,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire hbpf_pkg::cmd_t                cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    output hbpf_pkg::status_t                  status,
    output logic signed [SAMPLE_BITS-1:0]      m_filtered
);

    localparam int ADDR_BITS = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS = PROD_BITS + $clog2(TAPS);
    localparam int RND_BITS = ACC_BITS + 1;
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TAPS - 1);
    localparam logic signed [RND_BITS-1:0] RND_HALF =
        {{(RND_BITS - 1){1'b0}}, 1'b1} << (COEF_BITS - 2);
    localparam logic signed [RND_BITS-1:0] OUT_MAX =
        ({{(RND_BITS - 1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1'b1;
    localparam logic signed [RND_BITS-1:0] OUT_MIN = ~OUT_MAX;

    logic signed [SAMPLE_BITS-1:0] delay_mem [TAPS];
    logic signed [COEF_BITS-1:0] coef_rom [TAPS];

    logic [ADDR_BITS-1:0] wptr_reg, wptr_next;
    logic [ADDR_BITS-1:0] rptr_reg, rptr_next;
    logic [ADDR_BITS-1:0] tap_reg, tap_next;
    logic signed [SAMPLE_BITS-1:0] samp_q_reg;
    logic signed [COEF_BITS-1:0] coef_q_reg;
    logic rd_v_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic mul_v_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    logic signed [RND_BITS-1:0] rnd_sum;
    logic signed [RND_BITS-1:0] rnd_shift;

    for (genvar g = 0; g < TAPS; g++) begin : g_rom
        localparam logic signed [63:0] COEF_FULL =
            hbpf_pkg::coef_value(g, TAPS, COEF_BITS);
        assign coef_rom[g] = COEF_FULL[COEF_BITS-1:0];
    end

    assign status.last_tap = (tap_reg == LAST_ADDR);
    assign status.pipe_idle = !rd_v_reg && !mul_v_reg;
    assign m_filtered = filtered_reg;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        tap_next = tap_reg;
        if (cmd.load) begin
            wptr_next = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + 1'b1;
            rptr_next = wptr_reg;
            tap_next = '0;
        end else if (cmd.read) begin
            rptr_next = (rptr_reg == '0) ? LAST_ADDR : rptr_reg - 1'b1;
            tap_next = tap_reg + 1'b1;
        end
    end

    always_comb begin
        rnd_sum = RND_BITS'(acc_reg) + RND_HALF;
        rnd_shift = rnd_sum >>> (COEF_BITS - 1);
        priority if (rnd_shift > OUT_MAX) begin
            filtered_next = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (rnd_shift < OUT_MIN) begin
            filtered_next = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
            filtered_next = rnd_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delay_mem[wptr_reg] <= s_sample;
        end
        if (cmd.read) begin
            samp_q_reg <= delay_mem[rptr_reg];
            coef_q_reg <= coef_rom[tap_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rd_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
        end else begin
            wptr_reg <= wptr_next;
            rd_v_reg <= cmd.read;
            mul_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rptr_reg <= rptr_next;
        tap_reg <= tap_next;
        if (rd_v_reg) begin
            prod_reg <= samp_q_reg * coef_q_reg;
        end
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
        if (cmd.out_load) begin
            filtered_reg <= filtered_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hamming_bandpass_fir_filter_top.sv
// Band-pass FIR filter (80 to 128 Hz at a 256 Hz sample rate) with TAPS Hamming-windowed
// sinc taps held in a signed Q1.(COEF_BITS-1) ROM that is computed during elaboration. Each
// transfer on the s_ channel writes one sample into a circular delay memory; once more than
// TAPS samples of the current record have arrived (s_record_start restarts the count), each
// sample yields one result on the m_ channel, the sum of products rounded half up and
// saturated to SAMPLE_BITS bits. For a sample that yields a result, one shared
// multiply-accumulate walks the delay memory and the ROM one tap per cycle, followed by the
// read register and the product register, a drain state in which the controller waits until
// the pipeline is empty and a state in which the rounded result is registered once the
// previous result has been taken; s_ready is low meanwhile. During warm-up a sample is
// taken without a filtering pass and s_ready stays high. The result register lets the
// next sample be taken while a result still waits on m_ready.
`default_nettype none

module hamming_bandpass_fir_filter_top #(
    parameter int TAPS = 401,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                          s_record_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_filtered
);

    hbpf_pkg::cmd_t cmd;
    hbpf_pkg::status_t status;

    hbpf_ctrl #(
        .TAPS(TAPS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_record_start(s_record_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .status        (status)
    );

    hbpf_datapath #(
        .TAPS       (TAPS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_sample  (s_sample),
        .status    (status),
        .m_filtered(m_filtered)
    );

endmodule

`default_nettype wire

>>> rtl/core/hbpf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hbpf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic [SAMPLE_BITS-1:0] s_sample,
    input wire logic                   s_record_start,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_filtered
);

    // A stalled input transfer keeps its sample.
    `ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_sample))

    // A stalled result keeps its value.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_filtered))

    // The first sample of a record never yields a result, so input stays open.
    `ASSERT_NEXT(a_start_no_result, aclk, aresetn, s_valid && s_ready && s_record_start, s_ready)

    // A new result only appears after a filtering pass that held the input closed.
    `ASSERT_SAME(a_result_after_pass, aclk, aresetn, $rose(m_valid), !$past(s_ready))

endmodule

bind hamming_bandpass_fir_filter_top hbpf_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_hbpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_sample      (s_sample),
    .s_record_start(s_record_start),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_filtered    (m_filtered)
);

`default_nettype wire
